// ===== rtl/ecal_pkg.sv =====
// Package for the epoch seconds to calendar converter.
// Holds the conversion constants, the reciprocal constants and the stage structs.
// No dependencies.
`default_nettype none

package ecal_pkg;

   // Field widths
   localparam int EpochWidth  = 32;
   localparam int ZoneWidth   = 5;
   localparam int YearWidth   = 12;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int HourWidth   = 5;
   localparam int MinuteWidth = 6;
   localparam int SecondWidth = 6;

   // Internal widths
   localparam int LocalWidth  = 34;   // signed local seconds
   localparam int DaysWidth   = 16;   // days since 1970, below 47482
   localparam int SodWidth    = 17;   // second of day, below 86400
   localparam int CycleWidth  = 6;    // four-year cycles, at most 32
   localparam int CycDayWidth = 11;   // day within the cycle, below 1461
   localparam int DoyWidth    = 9;    // day of year, below 366
   localparam int RemHWidth   = 12;   // second of hour, below 3600

   // Calendar constants
   localparam int SecsPerMinute = 60;
   localparam int SecsPerHour   = 3600;
   localparam int SecsPerDay    = 86400;
   localparam int DaysPerCycle  = 1461;
   localparam int BaseYear      = 1970;
   localparam int DaysPerYear   = 365;
   localparam int DaysLeapYear  = 366;
   localparam int ZoneReset     = 8;
   localparam logic [32:0] LimitSeconds = 33'd4102444800;

   // Year boundaries inside a four-year cycle; the third year is the leap year.
   localparam int CycYear1 = DaysPerYear;
   localparam int CycYear2 = 2 * DaysPerYear;
   localparam int CycYear3 = 2 * DaysPerYear + DaysLeapYear;

   // Exact reciprocals: x / d == (x * Recip) >> Shift over the value range used.
   // Days: (local >> 7) / 675, input below 2^25.
   localparam int DayPreShift = 7;
   localparam logic [25:0] DayRecip = 26'd50903317;
   localparam int DayShift = 35;
   // Cycles: days / 1461, input below 2^16.
   localparam logic [16:0] CycRecip = 17'd91868;
   localparam int CycShift = 27;
   // Hours: second of day / 3600.
   localparam logic [16:0] HourRecip = 17'd74566;
   localparam int HourShift = 28;
   // Minutes: second of hour / 60.
   localparam logic [12:0] MinRecip = 13'd4370;
   localparam int MinShift = 18;

   localparam int NumMonths = 12;

   // First day of each month in a common year.
   localparam logic [DoyWidth-1:0] MonthStart [NumMonths] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // First day of a month, with February stretched in a leap year.
   function automatic logic [DoyWidth-1:0] month_start(input logic [3:0] idx,
                                                      input logic leap);
      logic [DoyWidth-1:0] base;
      base = (idx < 4'(NumMonths)) ? MonthStart[idx] : '0;
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

   // Word leaving the day split: whole days, second of day and range flag.
   typedef struct packed {
      logic [DaysWidth-1:0] days;
      logic [SodWidth-1:0]  sod;
      logic                 oor;
   } split_type;

   typedef struct packed {
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day_of_month;
   } date_type;

   typedef struct packed {
      logic [HourWidth-1:0]   hour;
      logic [MinuteWidth-1:0] minute;
      logic [SecondWidth-1:0] second;
   } clock_type;

endpackage

`default_nettype wire

// ===== rtl/ecal_day_split.sv =====
// Day split stages of the calendar converter: zone offset, range check,
// and division of local seconds into days and second of day (stages 1 to 3).
// Depends on ecal_pkg.
`default_nettype none

module ecal_day_split (
   input  logic                             clock,
   input  logic [ecal_pkg::EpochWidth-1:0]  epoch_seconds,
   input  logic signed [ecal_pkg::ZoneWidth-1:0] zone_offset_hours,
   output ecal_pkg::split_type              split
);
   import ecal_pkg::*;

   logic signed [17:0]           off_ext;
   logic signed [17:0]           off_secs;
   logic signed [LocalWidth-1:0] local_secs;
   logic                         oor_in;

   logic [31:0] local1_ff;
   logic        oor1_ff;
   logic [50:0] prod2_in;
   logic [50:0] prod2_ff;
   logic [31:0] local2_ff;
   logic        oor2_ff;
   logic [DaysWidth-1:0] days3_in;
   logic [31:0]          sod_full;
   split_type            split3_ff;

   // Stage 1: apply the zone offset and flag local times outside 1970 to 2099.
   assign off_ext    = 18'(zone_offset_hours);
   assign off_secs   = off_ext * $signed(18'(SecsPerHour));
   assign local_secs = $signed({2'b00, epoch_seconds}) + LocalWidth'(off_secs);
   assign oor_in     = local_secs[LocalWidth-1] || (local_secs[32:0] >= LimitSeconds);

   always_ff @(posedge clock) begin
      local1_ff <= local_secs[31:0];
      oor1_ff   <= oor_in;
   end

   // Stage 2: multiply by the reciprocal of the day length.
   assign prod2_in = 51'(local1_ff[31:DayPreShift]) * 51'(DayRecip);

   always_ff @(posedge clock) begin
      prod2_ff  <= prod2_in;
      local2_ff <= local1_ff;
      oor2_ff   <= oor1_ff;
   end

   // Stage 3: take the day count and the remainder within the day.
   assign days3_in = prod2_ff[DayShift +: DaysWidth];
   assign sod_full = local2_ff - (32'(days3_in) * 32'(SecsPerDay));

   always_ff @(posedge clock) begin
      split3_ff.days <= days3_in;
      split3_ff.sod  <= sod_full[SodWidth-1:0];
      split3_ff.oor  <= oor2_ff;
   end

   assign split = split3_ff;

endmodule

`default_nettype wire

// ===== rtl/ecal_date.sv =====
// Date stages of the calendar converter: days since 1970 into year, month
// and day of month (stages 4 to 7). Depends on ecal_pkg.
`default_nettype none

module ecal_date (
   input  logic                             clock,
   input  logic [ecal_pkg::DaysWidth-1:0]   days,
   output ecal_pkg::date_type               date
);
   import ecal_pkg::*;

   logic [32:0]            pcyc4_ff;
   logic [DaysWidth-1:0]   days4_ff;
   logic [CycleWidth-1:0]  cyc5_in;
   logic [DaysWidth-1:0]   rem5_full;
   logic [CycleWidth-1:0]  cyc5_ff;
   logic [CycDayWidth-1:0] rem5_ff;
   logic [1:0]             yoff6;
   logic [CycDayWidth-1:0] doy6_full;
   logic                   leap6_in;
   logic [YearWidth-1:0]   year6_ff;
   logic [DoyWidth-1:0]    doy6_ff;
   logic                   leap6_ff;
   logic [3:0]             mon7_idx;
   logic [DoyWidth-1:0]    dom7_full;
   date_type               date7_ff;

   // Stage 4: multiply by the reciprocal of the cycle length.
   always_ff @(posedge clock) begin
      pcyc4_ff <= 33'(days) * 33'(CycRecip);
      days4_ff <= days;
   end

   // Stage 5: cycle count and day within the cycle.
   assign cyc5_in   = pcyc4_ff[CycShift +: CycleWidth];
   assign rem5_full = days4_ff - (16'(cyc5_in) * 16'(DaysPerCycle));

   always_ff @(posedge clock) begin
      cyc5_ff <= cyc5_in;
      rem5_ff <= rem5_full[CycDayWidth-1:0];
   end

   // Stage 6: pick the year of the cycle; the third one is the leap year.
   always_comb begin
      yoff6     = 2'd0;
      doy6_full = rem5_ff;
      leap6_in  = 1'b0;
      if (rem5_ff < 11'(CycYear1)) begin
         yoff6     = 2'd0;
         doy6_full = rem5_ff;
      end else if (rem5_ff < 11'(CycYear2)) begin
         yoff6     = 2'd1;
         doy6_full = rem5_ff - 11'(CycYear1);
      end else if (rem5_ff < 11'(CycYear3)) begin
         yoff6     = 2'd2;
         doy6_full = rem5_ff - 11'(CycYear2);
         leap6_in  = 1'b1;
      end else begin
         yoff6     = 2'd3;
         doy6_full = rem5_ff - 11'(CycYear3);
      end
   end

   always_ff @(posedge clock) begin
      year6_ff <= 12'(BaseYear) + {4'd0, cyc5_ff, 2'b00} + {10'd0, yoff6};
      doy6_ff  <= doy6_full[DoyWidth-1:0];
      leap6_ff <= leap6_in;
   end

   // Stage 7: find the month whose first day is the last one not after the day.
   always_comb begin
      mon7_idx = 4'd0;
      for (int k = 1; k < NumMonths; k++) begin
         if (doy6_ff >= month_start(4'(k), leap6_ff)) begin
            mon7_idx = 4'(k);
         end
      end
   end

   assign dom7_full = doy6_ff - month_start(mon7_idx, leap6_ff) + 9'd1;

   always_ff @(posedge clock) begin
      date7_ff.year         <= year6_ff;
      date7_ff.month        <= mon7_idx + 4'd1;
      date7_ff.day_of_month <= dom7_full[DayWidth-1:0];
   end

   assign date = date7_ff;

endmodule

`default_nettype wire

// ===== rtl/ecal_clock.sv =====
// Time of day stages of the calendar converter: second of day into hour,
// minute and second (stages 4 to 7). Depends on ecal_pkg.
`default_nettype none

module ecal_clock (
   input  logic                           clock,
   input  logic [ecal_pkg::SodWidth-1:0]  sod,
   output ecal_pkg::clock_type            tod
);
   import ecal_pkg::*;

   logic [32:0]          ph4_ff;
   logic [SodWidth-1:0]  sod4_ff;
   logic [HourWidth-1:0] hour5_in;
   logic [SodWidth-1:0]  remh5_full;
   logic [HourWidth-1:0] hour5_ff;
   logic [RemHWidth-1:0] remh5_ff;
   logic [23:0]          pm6_ff;
   logic [HourWidth-1:0] hour6_ff;
   logic [RemHWidth-1:0] remh6_ff;
   logic [MinuteWidth-1:0] min7_in;
   logic [RemHWidth-1:0]   sec7_full;
   clock_type              tod7_ff;

   // Stage 4: multiply by the reciprocal of the hour length.
   always_ff @(posedge clock) begin
      ph4_ff  <= 33'(sod) * 33'(HourRecip);
      sod4_ff <= sod;
   end

   // Stage 5: hour and second within the hour.
   assign hour5_in   = ph4_ff[HourShift +: HourWidth];
   assign remh5_full = sod4_ff - (17'(hour5_in) * 17'(SecsPerHour));

   always_ff @(posedge clock) begin
      hour5_ff <= hour5_in;
      remh5_ff <= remh5_full[RemHWidth-1:0];
   end

   // Stage 6: multiply by the reciprocal of the minute length.
   always_ff @(posedge clock) begin
      pm6_ff   <= 24'(remh5_ff) * 24'(MinRecip);
      hour6_ff <= hour5_ff;
      remh6_ff <= remh5_ff;
   end

   // Stage 7: minute and second within the minute.
   assign min7_in   = pm6_ff[MinShift +: MinuteWidth];
   assign sec7_full = remh6_ff - (12'(min7_in) * 12'(SecsPerMinute));

   always_ff @(posedge clock) begin
      tod7_ff.hour   <= hour6_ff;
      tod7_ff.minute <= min7_in;
      tod7_ff.second <= sec7_full[SecondWidth-1:0];
   end

   assign tod = tod7_ff;

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Top level of the epoch seconds to calendar converter.
// Instantiates ecal_day_split, ecal_date and ecal_clock; depends on ecal_pkg.
//
// Converts a 32-bit count of seconds since 1970-01-01 UTC into local year,
// month, day of month, hour, minute and second, after adding the whole-hour
// zone offset held in the configuration register (reset value 8). The block
// is a seven-stage pipeline that takes one word in every cycle: busy is never
// raised. The result of each accepted word is shown on the rsp_ ports with
// rsp_strobe for one cycle. The depth is set by the offset stage and three
// levels of constant-reciprocal division (day, then cycle and hour side by
// side, then minute), each a multiply stage followed by a subtract stage.
// The receiver must take every result in the cycle it is shown. Local times
// before 1970 or in 2100 and later give rsp_out_of_range high and all other
// fields zero. The configuration channel is always ready; write it only
// while no words are in flight.
`default_nettype none

module epoch_seconds_to_calendar (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input word
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ecal_pkg::EpochWidth-1:0]       req_epoch_seconds,
   // Result word
   output logic                                  rsp_strobe,
   output logic [ecal_pkg::YearWidth-1:0]        rsp_year,
   output logic [ecal_pkg::MonthWidth-1:0]       rsp_month,
   output logic [ecal_pkg::DayWidth-1:0]         rsp_day_of_month,
   output logic [ecal_pkg::HourWidth-1:0]        rsp_hour,
   output logic [ecal_pkg::MinuteWidth-1:0]      rsp_minute,
   output logic [ecal_pkg::SecondWidth-1:0]      rsp_second,
   output logic                                  rsp_out_of_range,
   // Configuration write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic signed [ecal_pkg::ZoneWidth-1:0] csr_zone_offset_hours
);
   import ecal_pkg::*;

   localparam int Stages    = 7;
   localparam int LateStages = 4;   // stages after the day split

   logic signed [ZoneWidth-1:0] zone_ff;
   logic [Stages-1:0]           vld_ff;
   logic [LateStages-1:0]       oor_ff;
   split_type                   split;
   date_type                    date;
   clock_type                   tod;
   logic                        zero;

   // The pipeline never stalls, and the register is always writable.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Zone offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZoneWidth'(ZoneReset);
      end else if (csr_valid && csr_ready) begin
         zone_ff <= csr_zone_offset_hours;
      end
   end

   // Valid bits travel alongside the datapath stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Stages-2:0], start && !busy};
      end
   end

   // Out-of-range flag follows the date and time stages.
   always_ff @(posedge clock) begin
      oor_ff <= {oor_ff[LateStages-2:0], split.oor};
   end

   ecal_day_split u_split (
      .clock             (clock),
      .epoch_seconds     (req_epoch_seconds),
      .zone_offset_hours (zone_ff),
      .split             (split)
   );

   ecal_date u_date (
      .clock (clock),
      .days  (split.days),
      .date  (date)
   );

   ecal_clock u_clock (
      .clock (clock),
      .sod   (split.sod),
      .tod   (tod)
   );

   // Result word, forced to zero when out of range.
   assign zero             = oor_ff[LateStages-1];
   assign rsp_strobe       = vld_ff[Stages-1];
   assign rsp_out_of_range = zero;
   assign rsp_year         = zero ? '0 : date.year;
   assign rsp_month        = zero ? '0 : date.month;
   assign rsp_day_of_month = zero ? '0 : date.day_of_month;
   assign rsp_hour         = zero ? '0 : tod.hour;
   assign rsp_minute       = zero ? '0 : tod.minute;
   assign rsp_second       = zero ? '0 : tod.second;

`ifndef SYNTH
   // Every result word comes from an earlier accepted word.
   a_strobe_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 7))
      else $error("result strobe without a matching accepted word");

   // An in-range result holds a real date.
   a_date_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_out_of_range) |->
         (rsp_year >= 12'(BaseYear)) && (rsp_year < 12'd2100) &&
         (rsp_month >= 4'd1) && (rsp_month <= 4'd12) &&
         (rsp_day_of_month >= 5'd1))
      else $error("in-range result with an illegal date");

   // An in-range result holds a real time of day.
   a_time_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_out_of_range) |->
         (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59))
      else $error("in-range result with an illegal time of day");
`endif

endmodule

`default_nettype wire
